/* src/pvh_pkg.sv */
package pvh_pkg;

	// Fixed field widths.
	localparam int COORD_W   = 32;
	localparam int STEP_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int INDEX_W   = 15;
	localparam int BIN_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int PROD_W    = 64;
	localparam int FRAC_W    = 16;
	localparam int MUL_CNT_W = 3;

	// Count store depth and saturation value.
	localparam int STORE_DEPTH = 32768;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Default grid size on each axis.
	localparam int DEF_SIZE_X = 32;
	localparam int DEF_SIZE_Y = 32;
	localparam int DEF_SIZE_Z = 32;

	// Configuration register reset values.
	localparam logic [CFG_W-1:0] MIN_RESET  = 32'd0;
	localparam logic [CFG_W-1:0] STEP_RESET = 32'd65536;

	// Action codes of an input word.
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X  = 3'd0,
		REG_MIN_Y  = 3'd1,
		REG_MIN_Z  = 3'd2,
		REG_STEP_X = 3'd3,
		REG_STEP_Y = 3'd4,
		REG_STEP_Z = 3'd5
	} cfg_reg_t;

	// Axis select for the shared multiplier.
	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  accept;
		logic  clr_start;
		logic  clr_step;
		logic  mul_issue;
		axis_t mul_axis;
		logic  idx1;
		logic  idx2;
		logic  rd;
		logic  upd;
		logic  out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	// in_act is the action of the word on the input port, act the captured one.
	typedef struct packed {
		action_t in_act;
		action_t act;
		logic    clr_last;
	} dp_stat_t;

endpackage

/* src/pvh_ctrl.sv */
module pvh_ctrl
	import pvh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_MUL,
		S_IDX1,
		S_IDX2,
		S_RD,
		S_UPD,
		S_FIN
	} state_t;

	state_t               state_q;
	logic                 init_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Commands decoded from the current state.
	always_comb begin
		cmd           = '0;
		cmd.mul_axis  = AX_X;
		cmd.accept    = accept;
		cmd.clr_start = accept && (stat.in_act == ACT_CLEAR);
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
			end
			S_MUL: begin
				cmd.mul_issue = (mul_cnt_q < MUL_CNT_W'(3));
				case (mul_cnt_q)
					MUL_CNT_W'(1): cmd.mul_axis = AX_Y;
					MUL_CNT_W'(2): cmd.mul_axis = AX_Z;
					default:       cmd.mul_axis = AX_X;
				endcase
			end
			S_IDX1: cmd.idx1 = 1'b1;
			S_IDX2: cmd.idx2 = 1'b1;
			S_RD:   cmd.rd   = 1'b1;
			S_UPD:  cmd.upd  = 1'b1;
			S_FIN:  cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	// State, sequencing counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			init_q      <= 1'b1;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mul_cnt_q <= '0;
						case (stat.in_act)
							ACT_CLEAR: state_q <= S_CLR;
							ACT_ADD:   state_q <= S_MUL;
							ACT_READ:  state_q <= S_RD;
							default:   state_q <= S_FIN;
						endcase
					end
				end
				S_CLR: begin
					if (stat.clr_last) begin
						state_q <= init_q ? S_IDLE : S_FIN;
						init_q  <= 1'b0;
					end
				end
				S_MUL: begin
					// Three axes issued, then the multiplier drains before the index steps.
					if (mul_cnt_q == MUL_CNT_W'(4)) begin
						state_q <= S_IDX1;
					end else begin
						mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
					end
				end
				S_IDX1: state_q <= S_IDX2;
				S_IDX2: state_q <= S_RD;
				S_RD:   state_q <= (stat.act == ACT_ADD) ? S_UPD : S_FIN;
				S_UPD:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/pvh_dp.sv */
module pvh_dp
	import pvh_pkg::*;
#(
	parameter int SIZE_X = DEF_SIZE_X,
	parameter int SIZE_Y = DEF_SIZE_Y,
	parameter int SIZE_Z = DEF_SIZE_Z
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic [1:0]                 action,
	input  logic signed [COORD_W-1:0]  point_x,
	input  logic signed [COORD_W-1:0]  point_y,
	input  logic signed [COORD_W-1:0]  point_z,
	input  logic [INDEX_W-1:0]         read_index,
	output logic [COUNT_W-1:0]         voxel_count,
	output logic [INDEX_W-1:0]         voxel_index,
	output logic [COUNT_W-1:0]         peak_count,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat
);

	localparam int CELLS     = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int CLEAR_LEN = (CELLS > STORE_DEPTH) ? STORE_DEPTH : CELLS;
	localparam logic [INDEX_W-1:0] CLEAR_END = INDEX_W'(CLEAR_LEN - 1);
	localparam logic [BIN_W-1:0] TOP_X = BIN_W'(SIZE_X - 1);
	localparam logic [BIN_W-1:0] TOP_Y = BIN_W'(SIZE_Y - 1);
	localparam logic [BIN_W-1:0] TOP_Z = BIN_W'(SIZE_Z - 1);

	// Configuration registers.
	logic [COORD_W-1:0] min_x_q, min_y_q, min_z_q;
	logic [STEP_W-1:0]  step_x_q, step_y_q, step_z_q;

	// Captured input word.
	action_t            act_q;
	logic [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic [INDEX_W-1:0] idx_q;

	// Multiplier pipeline.
	logic               vld_s1, vld_s2;
	axis_t              axis_s1, axis_s2;
	logic               pos_s1, pos_s2;
	logic [COORD_W-1:0] mag_s1;
	logic [STEP_W-1:0]  step_s1;
	logic [PROD_W-1:0]  prod_s2;

	// Bins, index and count state.
	logic [BIN_W-1:0]   bx_q, by_q, bz_q;
	logic [COUNT_W-1:0] plane_q;
	logic [INDEX_W-1:0] clr_addr_q;
	logic [COUNT_W-1:0] voxel_mem_q [STORE_DEPTH];
	logic [COUNT_W-1:0] rdata_q;
	logic [COUNT_W-1:0] new_cnt_q;
	logic [COUNT_W-1:0] peak_q;
	logic [COUNT_W-1:0] out_count_q, out_peak_q;
	logic [INDEX_W-1:0] out_index_q;

	logic [COORD_W-1:0] sel_pt, sel_min;
	logic [STEP_W-1:0]  sel_step;
	logic [COORD_W:0]   diff;
	logic [PROD_W-FRAC_W-1:0] whole;
	logic [BIN_W-1:0]   bin;
	logic [COUNT_W-1:0] inc_cnt;
	logic               in_grid;
	logic [31:0]        plane_sum;
	logic [31:0]        lin_sum;

	assign stat.in_act   = action_t'(action);
	assign stat.act      = act_q;
	assign stat.clr_last = (clr_addr_q == CLEAR_END);

	assign voxel_count = out_count_q;
	assign voxel_index = out_index_q;
	assign peak_count  = out_peak_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= MIN_RESET;
			min_y_q  <= MIN_RESET;
			min_z_q  <= MIN_RESET;
			step_x_q <= STEP_RESET;
			step_y_q <= STEP_RESET;
			step_z_q <= STEP_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_X:  min_x_q  <= cfg_data;
				REG_MIN_Y:  min_y_q  <= cfg_data;
				REG_MIN_Z:  min_z_q  <= cfg_data;
				REG_STEP_X: step_x_q <= cfg_data;
				REG_STEP_Y: step_y_q <= cfg_data;
				REG_STEP_Z: step_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input word capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_NOP;
		end else if (cmd.accept) begin
			act_q <= action_t'(action);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pt_x_q <= point_x;
			pt_y_q <= point_y;
			pt_z_q <= point_z;
		end
	end

	// Operand select and offset for the axis being issued.
	always_comb begin
		case (cmd.mul_axis)
			AX_Y: begin
				sel_pt   = pt_y_q;
				sel_min  = min_y_q;
				sel_step = step_y_q;
			end
			AX_Z: begin
				sel_pt   = pt_z_q;
				sel_min  = min_z_q;
				sel_step = step_z_q;
			end
			default: begin
				sel_pt   = pt_x_q;
				sel_min  = min_x_q;
				sel_step = step_x_q;
			end
		endcase
		diff = {sel_pt[COORD_W-1], sel_pt} - {sel_min[COORD_W-1], sel_min};
	end

	// Valid bits of the multiplier pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_issue;
			vld_s2 <= vld_s1;
		end
	end

	// A positive offset is below 2^32 and multiplies as unsigned.
	always_ff @(posedge clk) begin
		axis_s1 <= cmd.mul_axis;
		pos_s1  <= !diff[COORD_W] && (diff != '0);
		mag_s1  <= diff[COORD_W-1:0];
		step_s1 <= sel_step;
		axis_s2 <= axis_s1;
		pos_s2  <= pos_s1;
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(step_s1);
	end

	// Drop the fraction and clamp the bin to the axis size.
	assign whole = prod_s2[PROD_W-1:FRAC_W];

	always_comb begin
		case (axis_s2)
			AX_Y: bin = (whole >= (PROD_W-FRAC_W)'(SIZE_Y)) ? TOP_Y : whole[BIN_W-1:0];
			AX_Z: bin = (whole >= (PROD_W-FRAC_W)'(SIZE_Z)) ? TOP_Z : whole[BIN_W-1:0];
			default: bin = (whole >= (PROD_W-FRAC_W)'(SIZE_X)) ? TOP_X : whole[BIN_W-1:0];
		endcase
		if (!pos_s2) begin
			bin = '0;
		end
	end

	// Linear index in two steps, one constant product each.
	assign plane_sum = 32'(by_q) + 32'(SIZE_Y) * 32'(bz_q);
	assign lin_sum   = 32'(bx_q) + 32'(SIZE_X) * 32'(plane_q);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			case (axis_s2)
				AX_Y:    by_q <= bin;
				AX_Z:    bz_q <= bin;
				default: bx_q <= bin;
			endcase
		end
		if (cmd.idx1) begin
			plane_q <= plane_sum[COUNT_W-1:0];
		end
		if (cmd.accept) begin
			idx_q <= read_index;
		end else if (cmd.idx2) begin
			idx_q <= lin_sum[INDEX_W-1:0];
		end
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + INDEX_W'(1);
		end
	end

	// Saturating increment of the read count.
	assign inc_cnt = (rdata_q == COUNT_MAX) ? COUNT_MAX : rdata_q + COUNT_W'(1);

	// Count store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			voxel_mem_q[clr_addr_q] <= '0;
		end else if (cmd.upd) begin
			voxel_mem_q[idx_q] <= inc_cnt;
		end
		if (cmd.rd) begin
			rdata_q <= voxel_mem_q[idx_q];
		end
		if (cmd.upd) begin
			new_cnt_q <= inc_cnt;
		end
	end

	// Running peak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.clr_start) begin
			peak_q <= '0;
		end else if (cmd.upd && (inc_cnt > peak_q)) begin
			peak_q <= inc_cnt;
		end
	end

	// Result word.
	assign in_grid = (32'(idx_q) < 32'(CELLS));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_peak_q <= peak_q;
			case (act_q)
				ACT_ADD: begin
					out_count_q <= new_cnt_q;
					out_index_q <= idx_q;
				end
				ACT_READ: begin
					out_count_q <= in_grid ? rdata_q : '0;
					out_index_q <= idx_q;
				end
				default: begin
					out_count_q <= '0;
					out_index_q <= '0;
				end
			endcase
		end
	end

endmodule

/* src/point_cloud_voxel_histogram.sv */
// Channel  | Handshake            | Word
// ---------+----------------------+---------------------------------------------
// input    | in_valid, in_stall   | action, point_x, point_y, point_z, read_index
// output   | out_valid, out_stall | voxel_count, voxel_index, peak_count
// config   | cfg_write            | cfg_index, cfg_data
//
// An add steps through S_MUL, S_IDX1, S_IDX2, S_RD, S_UPD and S_FIN: one shared
// 32x32 multiplier bins the three axes in turn, then the count store does one read and
// one write. A read steps through S_RD and S_FIN. A clear sweeps min(SIZE_X*SIZE_Y*SIZE_Z,
// 32768) entries of the store, one entry a cycle, then passes through S_FIN.
// After reset the same sweep runs with in_stall high.
// The next word is taken while a result still waits under out_stall.
module point_cloud_voxel_histogram
	import pvh_pkg::*;
#(
	parameter int SIZE_X = DEF_SIZE_X,
	parameter int SIZE_Y = DEF_SIZE_Y,
	parameter int SIZE_Z = DEF_SIZE_Z
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic [INDEX_W-1:0]        read_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COUNT_W-1:0]        voxel_count,
	output logic [INDEX_W-1:0]        voxel_index,
	output logic [COUNT_W-1:0]        peak_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	pvh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Binning arithmetic, count store and result register.
	pvh_dp #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.read_index  (read_index),
		.voxel_count (voxel_count),
		.voxel_index (voxel_index),
		.peak_count  (peak_count),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

/* bench/tb_top.sv */
module tb_top;
	import pvh_pkg::*;

	localparam int SIZE_X = DEF_SIZE_X;
	localparam int SIZE_Y = DEF_SIZE_Y;
	localparam int SIZE_Z = DEF_SIZE_Z;
	localparam int CELLS = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int HOT_ADDS = 80;
	localparam int MAX_REPORTS = 100;

	// One input word and one result word as the bench sees them.
	typedef struct {
		action_t                  act;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [INDEX_W-1:0]       ridx;
	} hist_word_t;

	typedef struct {
		logic [COUNT_W-1:0] cnt;
		logic [INDEX_W-1:0] idx;
		logic [COUNT_W-1:0] peak;
	} bin_result_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_X;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_CLEAR;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic [INDEX_W-1:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COUNT_W-1:0] voxel_count;
	logic [INDEX_W-1:0] voxel_index;
	logic [COUNT_W-1:0] peak_count;

	// Bench copy of the grid, the peak and the registers.
	logic [COUNT_W-1:0] voxel_model [STORE_DEPTH];
	logic [COUNT_W-1:0] peak_model;
	logic signed [COORD_W-1:0] lo [3];
	logic [STEP_W-1:0] step [3];

	hist_word_t word_queue [$];
	bin_result_t expected_bins [$];
	logic [INDEX_W-1:0] touched [$];

	int words_queued = 0;
	int words_taken = 0;
	int results_seen = 0;
	int errors = 0;
	int n_add = 0;
	int n_read = 0;
	int n_clear = 0;
	int n_nop = 0;
	int n_settings = 0;
	int clears_left = 4;
	bit in_took = 1'b0;
	bit calm = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	point_cloud_voxel_histogram #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.voxel_count(voxel_count),
		.voxel_index(voxel_index),
		.peak_count(peak_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bin one axis: exact difference, exact product, drop the fraction, clamp.
	function automatic int unsigned bin_of(logic signed [COORD_W-1:0] raw,
			logic signed [COORD_W-1:0] base, logic [STEP_W-1:0] inv, int unsigned size);
		logic signed [COORD_W:0] diff;
		logic [PROD_W-1:0] prod;
		diff = {raw[COORD_W-1], raw} - {base[COORD_W-1], base};
		if (diff <= 0)
			return 0;
		prod = {32'd0, diff[COORD_W-1:0]} * {32'd0, inv};
		prod = prod >> FRAC_W;
		if (prod >= 64'(size))
			return size - 1;
		return prod[31:0];
	endfunction

	function automatic logic [INDEX_W-1:0] voxel_of(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
		int unsigned bx, by, bz, lin;
		bx = bin_of(px, lo[0], step[0], SIZE_X);
		by = bin_of(py, lo[1], step[1], SIZE_Y);
		bz = bin_of(pz, lo[2], step[2], SIZE_Z);
		lin = bx + SIZE_X * (by + SIZE_Y * bz);
		return lin[INDEX_W-1:0];
	endfunction

	// Apply one word to the bench grid and return the result it must produce.
	function automatic bin_result_t predict_voxel(hist_word_t w);
		bin_result_t r;
		r = '{default: '0};
		case (w.act)
			ACT_CLEAR: begin
				foreach (voxel_model[i])
					voxel_model[i] = '0;
				peak_model = '0;
				n_clear++;
			end
			ACT_ADD: begin
				r.idx = voxel_of(w.px, w.py, w.pz);
				r.cnt = voxel_model[r.idx];
				if (r.cnt != COUNT_MAX)
					r.cnt = r.cnt + 1'b1;
				voxel_model[r.idx] = r.cnt;
				if (r.cnt > peak_model)
					peak_model = r.cnt;
				n_add++;
			end
			ACT_READ: begin
				r.idx = w.ridx;
				r.cnt = (int'(w.ridx) < CELLS) ? voxel_model[w.ridx] : '0;
				n_read++;
			end
			default: begin
				n_nop++;
			end
		endcase
		r.peak = peak_model;
		return r;
	endfunction

	// Coordinates mostly land in the grid of the current setting, often in its first three bins.
	function automatic logic signed [COORD_W-1:0] pick_coord(int ax);
		longint unsigned span;
		int unsigned nb;
		if ($urandom_range(0, 1) == 0)
			nb = 3;
		else
			nb = ((ax == 0) ? SIZE_X : (ax == 1) ? SIZE_Y : SIZE_Z) + 2;
		if (step[ax] == 0)
			span = 1000;
		else
			span = (64'(nb) << FRAC_W) / step[ax] + 1;
		if (span > 64'h7FFF_FFFF)
			span = 64'h7FFF_FFFF;
		case ($urandom_range(0, 19))
			0, 1, 2: return $urandom;
			3, 4: return lo[ax] - $urandom_range(0, 1000);
			default: return lo[ax] + $urandom_range(0, span[31:0]);
		endcase
	endfunction

	task automatic note_error(string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$error("%s", msg);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got)
			note_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endtask

	task automatic push_word(action_t a, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
			logic [INDEX_W-1:0] ri);
		hist_word_t w;
		w.act = a;
		w.px = x;
		w.py = y;
		w.pz = z;
		w.ridx = ri;
		word_queue.push_back(w);
		words_queued++;
	endtask

	// Register writes go out one per cycle while the block is idle.
	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		case (r)
			REG_MIN_X: lo[0] = d;
			REG_MIN_Y: lo[1] = d;
			REG_MIN_Z: lo[2] = d;
			REG_STEP_X: step[0] = d;
			REG_STEP_Y: step[1] = d;
			REG_STEP_Z: step[2] = d;
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [CFG_W-1:0] mx, logic [CFG_W-1:0] my,
			logic [CFG_W-1:0] mz, logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy,
			logic [CFG_W-1:0] sz);
		write_reg(REG_MIN_X, mx);
		write_reg(REG_MIN_Y, my);
		write_reg(REG_MIN_Z, mz);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_STEP_Z, sz);
		@(negedge clk);
		cfg_write <= 1'b0;
		n_settings++;
	endtask

	// Wait until every queued word is taken and every result has come back.
	task automatic wait_idle();
		while (words_taken != words_queued || expected_bins.size() != 0)
			@(negedge clk);
	endtask

	// Mostly adds, with most reads aimed at voxels added recently.
	task automatic fill_random(int n);
		hist_word_t w;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 999);
			w.px = pick_coord(0);
			w.py = pick_coord(1);
			w.pz = pick_coord(2);
			w.ridx = $urandom;
			if (r < 3 && clears_left > 0) begin
				w.act = ACT_CLEAR;
				clears_left--;
			end else if (r < 40) begin
				w.act = ACT_NOP;
			end else if (r < 260) begin
				w.act = ACT_READ;
				if (touched.size() > 0 && $urandom_range(0, 9) < 7)
					w.ridx = touched[$urandom_range(0, touched.size() - 1)];
			end else begin
				w.act = ACT_ADD;
				touched.push_back(voxel_of(w.px, w.py, w.pz));
				if (touched.size() > 48)
					void'(touched.pop_front());
			end
			push_word(w.act, w.px, w.py, w.pz, w.ridx);
		end
	endtask

	// Driver: presents queued words in bursts with random gaps between them.
	always @(negedge clk) begin
		hist_word_t w;
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (gap_left > 0 && !calm) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_queue.size() > 0) begin
					w = word_queue.pop_front();
					in_valid <= 1'b1;
					action <= w.act;
					point_x <= w.px;
					point_y <= w.py;
					point_z <= w.pz;
					read_index <= w.ridx;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
							: $urandom_range(0, 3);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_took = 1'b0;
		end
	end

	// Receiver: stall pattern switches between modes of random length.
	always @(negedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PERIODIC: out_stall <= ((mode_left % 16) < 10);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// Monitor: check results first, then predict for a word taken at this edge.
	always @(posedge clk) begin
		bin_result_t want;
		hist_word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_bins.size() == 0) begin
					note_error($sformatf("unexpected result: count %0d index %0d peak %0d",
						voxel_count, voxel_index, peak_count));
				end else begin
					want = expected_bins.pop_front();
					check_field("voxel_count", want.cnt, voxel_count);
					check_field("voxel_index", want.idx, voxel_index);
					check_field("peak_count", want.peak, peak_count);
				end
			end
			if (in_valid && !in_stall) begin
				w.act = action_t'(action);
				w.px = point_x;
				w.py = point_y;
				w.pz = point_z;
				w.ridx = read_index;
				expected_bins.push_back(predict_voxel(w));
				words_taken++;
				in_took = 1'b1;
			end
		end
	end

	initial begin
		foreach (voxel_model[i])
			voxel_model[i] = '0;
		peak_model = '0;
		for (int a = 0; a < 3; a++) begin
			lo[a] = MIN_RESET;
			step[a] = STEP_RESET;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset registers: one raw unit per bin.
		push_word(ACT_READ, 0, 0, 0, 0);
		push_word(ACT_READ, 0, 0, 0, 15'h7FFF);
		push_word(ACT_ADD, 0, 0, 0, 0);
		push_word(ACT_ADD, 0, 0, 0, 15'h7FFF);
		push_word(ACT_ADD, 31, 31, 31, 0);
		// Below the minimum on every axis.
		push_word(ACT_ADD, -1, 32'sh8000_0000, -5, 0);
		// Past the far edge of the grid on every axis.
		push_word(ACT_ADD, 32, 1000, 32'sh7FFF_FFFF, 0);
		push_word(ACT_ADD, 5, 7, 9, 0);
		push_word(ACT_READ, 0, 0, 0, 15'(5 + SIZE_X * (7 + SIZE_Y * 9)));
		push_word(ACT_READ, 0, 0, 0, 0);
		push_word(ACT_NOP, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 15'h7FFF);
		push_word(ACT_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 31, 0);
		push_word(ACT_CLEAR, -1, -1, -1, 15'h7FFF);
		push_word(ACT_READ, 0, 0, 0, 0);
		push_word(ACT_READ, 0, 0, 0, 15'h7FFF);
		push_word(ACT_NOP, 0, 0, 0, 0);
		push_word(ACT_ADD, 1, 2, 3, 0);
		push_word(ACT_READ, 0, 0, 0, 15'(1 + SIZE_X * (2 + SIZE_Y * 3)));
		wait_idle();

		// Random words under several register settings, extremes included.
		apply_setting(MIN_RESET, MIN_RESET, MIN_RESET, STEP_RESET, STEP_RESET, STEP_RESET);
		fill_random(175);
		wait_idle();
		apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		fill_random(175);
		wait_idle();
		apply_setting(32'h7FFF_FFFF, -32'sd1000, 32'sd12345, 32'hFFFF_FFFF, 32'd0, 32'h8000);
		fill_random(175);
		wait_idle();
		apply_setting($urandom, $urandom, $urandom, $urandom_range(32'h100, 32'h40000),
			$urandom_range(32'h100, 32'h40000), $urandom_range(32'h100, 32'h40000));
		fill_random(175);
		wait_idle();
		apply_setting(32'sd100, -32'sd100, 32'sd7, 32'h10_0000, 32'h1_0000, 32'h2000);
		fill_random(175);
		wait_idle();
		apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		fill_random(175);
		wait_idle();

		// Hit one voxel over and over with no idling on either side.
		apply_setting(MIN_RESET, MIN_RESET, MIN_RESET, STEP_RESET, STEP_RESET, STEP_RESET);
		calm = 1'b1;
		for (int k = 0; k < HOT_ADDS; k++)
			push_word(ACT_ADD, 3, 4, 5, 0);
		push_word(ACT_READ, 0, 0, 0, 15'(3 + SIZE_X * (4 + SIZE_Y * 5)));
		push_word(ACT_NOP, 0, 0, 0, 0);
		wait_idle();

		// Let any stray result show up before the verdict.
		repeat (50) @(negedge clk);
		$display("Run covered %0d adds, %0d reads, %0d clears and %0d no-ops over %0d settings.",
			n_add, n_read, n_clear, n_nop, n_settings);
		$display("Checked %0d results, including one voxel hit back to back many times.",
			results_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* point_cloud_voxel_histogram.f */
src/pvh_pkg.sv
src/pvh_ctrl.sv
src/pvh_dp.sv
src/point_cloud_voxel_histogram.sv
bench/tb_top.sv
